>>> design/owtr_pkg.sv
// shared types, register map and constants of the 1-Wire temperature read master
`default_nettype none

package owtr_pkg;

    localparam int OWTR_TIMER_BITS = 10;
    localparam int OWTR_CFG_W      = 10;
    localparam int OWTR_ADDR_W     = 5;
    localparam int OWTR_DATA_W     = 32;

    // rom and function commands sent LSB first
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    localparam logic [OWTR_CFG_W-1:0] RST_RESET_LOW  = 10'd750;
    localparam logic [OWTR_CFG_W-1:0] RST_PRES_TMO   = 10'd255;
    localparam logic [OWTR_CFG_W-1:0] RST_RECOVERY   = 10'd750;
    localparam logic [OWTR_CFG_W-1:0] RST_SLOT_START = 10'd8;
    localparam logic [OWTR_CFG_W-1:0] RST_SLOT_HOLD  = 10'd75;

    typedef enum logic [2:0] {
        REG_RESET_LOW  = 3'd0,
        REG_PRES_TMO   = 3'd1,
        REG_RECOVERY   = 3'd2,
        REG_SLOT_START = 3'd3,
        REG_SLOT_HOLD  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_RST1  = 4'd1,
        ST_PRES1 = 4'd2,
        ST_REC1  = 4'd3,
        ST_W_CC1 = 4'd4,
        ST_W_44  = 4'd5,
        ST_RST2  = 4'd6,
        ST_PRES2 = 4'd7,
        ST_REC2  = 4'd8,
        ST_W_CC2 = 4'd9,
        ST_W_BE  = 4'd10,
        ST_R_LO  = 4'd11,
        ST_R_HI  = 4'd12
    } t_step;

    typedef struct packed {
        logic [OWTR_CFG_W-1:0] reset_low_ticks;
        logic [OWTR_CFG_W-1:0] presence_timeout_ticks;
        logic [OWTR_CFG_W-1:0] reset_recovery_ticks;
        logic [OWTR_CFG_W-1:0] slot_start_ticks;
        logic [OWTR_CFG_W-1:0] slot_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic req_type;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] temperature;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/owtr_cfg.sv
// apb register file holding the bus timing registers
`default_nettype none

module owtr_cfg (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [owtr_pkg::OWTR_ADDR_W-1:0]  paddr,
    input  wire  [owtr_pkg::OWTR_DATA_W-1:0]  pwdata,
    output logic [owtr_pkg::OWTR_DATA_W-1:0]  prdata,
    output logic                              pready,
    output owtr_pkg::t_cfg                    o_cfg
);
    import owtr_pkg::*;

    t_cfg                  r_cfg;
    t_reg_idx              reg_idx;
    logic                  wr_en;
    logic [OWTR_CFG_W-1:0] wr_val;
    logic [OWTR_CFG_W-1:0] rd_val;

    assign reg_idx = t_reg_idx'(paddr[OWTR_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[OWTR_CFG_W-1:0];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks        <= RST_RESET_LOW;
            r_cfg.presence_timeout_ticks <= RST_PRES_TMO;
            r_cfg.reset_recovery_ticks   <= RST_RECOVERY;
            r_cfg.slot_start_ticks       <= RST_SLOT_START;
            r_cfg.slot_hold_ticks        <= RST_SLOT_HOLD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RESET_LOW:  r_cfg.reset_low_ticks        <= wr_val;
                REG_PRES_TMO:   r_cfg.presence_timeout_ticks <= wr_val;
                REG_RECOVERY:   r_cfg.reset_recovery_ticks   <= wr_val;
                REG_SLOT_START: r_cfg.slot_start_ticks       <= wr_val;
                REG_SLOT_HOLD:  r_cfg.slot_hold_ticks        <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RESET_LOW:  rd_val = r_cfg.reset_low_ticks;
            REG_PRES_TMO:   rd_val = r_cfg.presence_timeout_ticks;
            REG_RECOVERY:   rd_val = r_cfg.reset_recovery_ticks;
            REG_SLOT_START: rd_val = r_cfg.slot_start_ticks;
            REG_SLOT_HOLD:  rd_val = r_cfg.slot_hold_ticks;
            default:        rd_val = '0;
        endcase
    end

    assign prdata = {{(OWTR_DATA_W-OWTR_CFG_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

>>> design/owtr_seq.sv
// bus sequencer: one tick per accepted item, state advanced in a single pass
`default_nettype none

module owtr_seq #(
    parameter int TIMER_BITS = owtr_pkg::OWTR_TIMER_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  owtr_pkg::t_in_item   i_item,
    input  owtr_pkg::t_cfg       i_cfg,
    output owtr_pkg::t_out_item  o_res
);
    import owtr_pkg::*;

    localparam int CMP_W = ((TIMER_BITS > OWTR_CFG_W) ? TIMER_BITS : OWTR_CFG_W) + 1;

    t_step                 r_step,    n_step;
    logic [2:0]            r_bit,     n_bit;
    logic [TIMER_BITS-1:0] r_timer,   n_timer;
    logic                  r_phase,   n_phase;
    logic [7:0]            r_shift,   n_shift;
    logic [7:0]            r_low,     n_low;
    logic [7:0]            r_reading, n_reading;

    // effective state once a start request in idle has been taken
    t_step                 e_step;
    logic [2:0]            e_bit;
    logic [TIMER_BITS-1:0] e_timer;
    logic                  e_phase;

    logic [OWTR_CFG_W-1:0] len_sel;
    logic [CMP_W-1:0]      timer_inc;
    logic                  over;
    logic [7:0]            shift_rd;
    logic                  do_enter;
    t_step                 enter_to;
    t_step                 step_succ;

    always_comb begin
        if (r_step == ST_IDLE && i_item.req_type) begin
            e_step  = ST_RST1;
            e_bit   = '0;
            e_timer = '0;
            e_phase = 1'b0;
        end else begin
            e_step  = r_step;
            e_bit   = r_bit;
            e_timer = r_timer;
            e_phase = r_phase;
        end
    end

    always_comb begin
        unique case (e_step)
            ST_RST1, ST_RST2:                      len_sel = i_cfg.reset_low_ticks;
            ST_PRES1, ST_PRES2:                    len_sel = i_cfg.presence_timeout_ticks;
            ST_REC1, ST_REC2:                      len_sel = i_cfg.reset_recovery_ticks;
            ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE:
                len_sel = e_phase ? i_cfg.slot_hold_ticks : i_cfg.slot_start_ticks;
            default:                               len_sel = i_cfg.slot_hold_ticks;
        endcase
    end

    // a phase ends when the count reaches its length or the timer saturates
    assign timer_inc = CMP_W'(e_timer) + CMP_W'(1);
    assign over      = (timer_inc >= CMP_W'(len_sel)) || (&e_timer);
    assign step_succ = t_step'(4'(e_step) + 4'd1);
    // read slot samples the line on its first released tick
    assign shift_rd  = (e_timer == '0) ? {i_item.line_level, r_shift[7:1]} : r_shift;

    // next state
    always_comb begin
        n_step    = e_step;
        n_bit     = e_bit;
        n_timer   = e_timer;
        n_phase   = e_phase;
        n_shift   = r_shift;
        n_low     = r_low;
        n_reading = r_reading;
        do_enter  = 1'b0;
        enter_to  = ST_IDLE;
        unique case (e_step)
            ST_RST1, ST_RST2, ST_REC1, ST_REC2: begin
                if (over) begin
                    do_enter = 1'b1;
                    enter_to = step_succ;
                end else begin
                    n_timer = e_timer + TIMER_BITS'(1);
                end
            end
            ST_PRES1, ST_PRES2: begin
                if (!i_item.line_level || over) begin
                    do_enter = 1'b1;
                    enter_to = step_succ;
                end else begin
                    n_timer = e_timer + TIMER_BITS'(1);
                end
            end
            ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE: begin
                if (!over) begin
                    n_timer = e_timer + TIMER_BITS'(1);
                end else if (!e_phase) begin
                    n_phase = 1'b1;
                    n_timer = '0;
                end else begin
                    n_shift = {1'b0, r_shift[7:1]};
                    if (e_bit == 3'd7) begin
                        do_enter = 1'b1;
                        enter_to = step_succ;
                    end else begin
                        n_bit   = e_bit + 3'd1;
                        n_phase = 1'b0;
                        n_timer = '0;
                    end
                end
            end
            ST_R_LO, ST_R_HI: begin
                if (!e_phase) begin
                    n_phase = 1'b1;
                    n_timer = '0;
                end else begin
                    n_shift = shift_rd;
                    if (!over) begin
                        n_timer = e_timer + TIMER_BITS'(1);
                    end else if (e_bit != 3'd7) begin
                        n_bit   = e_bit + 3'd1;
                        n_phase = 1'b0;
                        n_timer = '0;
                    end else if (e_step == ST_R_LO) begin
                        n_low    = shift_rd;
                        do_enter = 1'b1;
                        enter_to = ST_R_HI;
                    end else begin
                        n_reading = {shift_rd[3:0], r_low[7:4]};
                        do_enter  = 1'b1;
                        enter_to  = ST_IDLE;
                    end
                end
            end
            default: begin
                do_enter = 1'b1;
                enter_to = ST_IDLE;
            end
        endcase
        if (do_enter) begin
            n_step  = enter_to;
            n_bit   = '0;
            n_timer = '0;
            n_phase = 1'b0;
            case (enter_to)
                ST_W_CC1, ST_W_CC2: n_shift = CMD_SKIP_ROM;
                ST_W_44:            n_shift = CMD_CONVERT;
                ST_W_BE:            n_shift = CMD_READ_SP;
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res.drive_low   = 1'b0;
        o_res.busy_res    = 1'b1;
        o_res.done_res    = 1'b0;
        o_res.temperature = n_reading;
        unique case (e_step)
            ST_RST1, ST_RST2:                      o_res.drive_low = 1'b1;
            ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE:  o_res.drive_low = !e_phase || !r_shift[0];
            ST_R_LO, ST_R_HI: begin
                o_res.drive_low = !e_phase;
                if (e_step == ST_R_HI && e_phase && over && e_bit == 3'd7) begin
                    o_res.busy_res = 1'b0;
                    o_res.done_res = 1'b1;
                end
            end
            ST_PRES1, ST_PRES2, ST_REC1, ST_REC2: ;
            default:                               o_res.busy_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_bit     <= '0;
            r_timer   <= '0;
            r_phase   <= 1'b0;
            r_shift   <= '0;
            r_low     <= '0;
            r_reading <= '0;
        end else if (i_accept) begin
            r_step    <= n_step;
            r_bit     <= n_bit;
            r_timer   <= n_timer;
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_low     <= n_low;
            r_reading <= n_reading;
        end
    end

endmodule

`default_nettype wire

>>> design/onewire_temperature_read_master_top.sv
// 1-Wire temperature read master: tick channel in, per-tick result channel out, apb registers
//
// Each transfer on the input channel is one bus timing tick carrying the sampled line
// level and an optional start request. Every accepted tick yields exactly one result
// transfer: drive_low for that tick, busy, a one-tick done flag and the last whole-degree
// reading. A start request in idle runs reset, presence wait, recovery, skip-rom and
// convert, a second reset, skip-rom and read-scratchpad, then a two-byte read.
// The result of a tick is registered: it sits in the output register on the cycle
// after its transfer. One tick is taken per cycle unless the input stalls; the sequencer
// state advances in a single pass from the accepted tick, bounded by the timer compare.
// When the receiver stalls, the output register holds its result and the input stall
// rises only while that register is full and stalled, so a tick still enters whenever
// the pending result drains in the same cycle.
// Reset (synchronous, active low) returns the sequencer to idle, clears the reading and
// loads the timing registers with their defaults. The user must write timing registers over
// apb only while the block is idle; the block does not enforce this. pready is always high.
`default_nettype none

module onewire_temperature_read_master_top #(
    parameter int TIMER_BITS = owtr_pkg::OWTR_TIMER_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  owtr_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output owtr_pkg::t_out_item               o_out_item,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [owtr_pkg::OWTR_ADDR_W-1:0]  paddr,
    input  wire  [owtr_pkg::OWTR_DATA_W-1:0]  pwdata,
    output logic [owtr_pkg::OWTR_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import owtr_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    t_out_item r_out;
    logic      r_out_valid;
    logic      accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    owtr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    owtr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // every accepted tick produces a result on the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted tick produced no result");

    // input stalls only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a pending result");

    // the finishing tick is never flagged busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("done and busy together");

    // the reading changes only on a done result
    a_temp_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && !$stable(r_out.temperature)) |-> r_out.done_res)
        else $error("reading changed without done");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the 1-Wire temperature read master: tick driver, result monitor
`timescale 1ns / 100ps

module testbench;
    import owtr_pkg::*;

    localparam int TIMER_BITS = OWTR_TIMER_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;
    // register slots past the end of the map, writes there must be dropped
    localparam logic [2:0] REG_BEYOND_LO = 3'd5;
    localparam logic [2:0] REG_BEYOND_HI = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [OWTR_ADDR_W-1:0] paddr = '0;
    logic [OWTR_DATA_W-1:0] pwdata = '0;
    logic [OWTR_DATA_W-1:0] prdata;
    logic                   pready;

    onewire_temperature_read_master_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state of the sequencer
    t_cfg                  timing;
    t_step                 seq_step;
    logic [2:0]            bit_idx;
    logic [TIMER_BITS-1:0] tick_count;
    logic [7:0]            shift_reg;
    logic [7:0]            low_byte;
    logic [7:0]            reading;
    logic                  slot_body;

    t_in_item  ticks_to_send[$];
    t_out_item bus_results_due[$];

    bit calm_tail = 1'b0;
    bit hold_out_req = 1'b0;
    bit in_taken = 1'b0;
    int mismatch_count = 0;
    int ticks_taken = 0;
    int reads_completed = 0;
    int input_stall_cycles = 0;
    int settings_used = 0;

    function automatic bit slot_timer_done(logic [OWTR_CFG_W-1:0] len);
        if (int'(tick_count) + 1 >= int'(len) || tick_count == TIMER_TOP)
            return 1'b1;
        tick_count = tick_count + TIMER_BITS'(1);
        return 1'b0;
    endfunction

    function automatic void enter_step(t_step s);
        seq_step = s;
        tick_count = '0;
        slot_body = 1'b0;
        bit_idx = '0;
        case (s)
            ST_W_CC1, ST_W_CC2: shift_reg = CMD_SKIP_ROM;
            ST_W_44:            shift_reg = CMD_CONVERT;
            ST_W_BE:            shift_reg = CMD_READ_SP;
            default:            ;
        endcase
    endfunction

    function automatic void advance_bit();
        bit_idx = bit_idx + 3'd1;
        slot_body = 1'b0;
        tick_count = '0;
    endfunction

    function automatic t_out_item predict_bus_tick(t_in_item tick);
        t_out_item res;
        t_step     nxt;
        res = '0;
        if (seq_step == ST_IDLE && tick.req_type)
            enter_step(ST_RST1);
        nxt = t_step'(seq_step + 4'd1);
        case (seq_step)
            ST_RST1, ST_RST2: begin
                res.drive_low = 1'b1;
                res.busy_res = 1'b1;
                if (slot_timer_done(timing.reset_low_ticks))
                    enter_step(nxt);
            end
            ST_PRES1, ST_PRES2: begin
                res.busy_res = 1'b1;
                // a low line ends the wait, the answer itself is never checked
                if (!tick.line_level)
                    enter_step(nxt);
                else if (slot_timer_done(timing.presence_timeout_ticks))
                    enter_step(nxt);
            end
            ST_REC1, ST_REC2: begin
                res.busy_res = 1'b1;
                if (slot_timer_done(timing.reset_recovery_ticks))
                    enter_step(nxt);
            end
            ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE: begin
                res.busy_res = 1'b1;
                if (!slot_body) begin
                    res.drive_low = 1'b1;
                    if (slot_timer_done(timing.slot_start_ticks)) begin
                        slot_body = 1'b1;
                        tick_count = '0;
                    end
                end else begin
                    res.drive_low = ~shift_reg[0];
                    if (slot_timer_done(timing.slot_hold_ticks)) begin
                        shift_reg = shift_reg >> 1;
                        if (bit_idx == 3'd7)
                            enter_step(nxt);
                        else
                            advance_bit();
                    end
                end
            end
            ST_R_LO, ST_R_HI: begin
                res.busy_res = 1'b1;
                if (!slot_body) begin
                    res.drive_low = 1'b1;
                    slot_body = 1'b1;
                    tick_count = '0;
                end else begin
                    // line is sampled on the first released tick of the slot
                    if (tick_count == '0)
                        shift_reg = {tick.line_level, shift_reg[7:1]};
                    if (slot_timer_done(timing.slot_hold_ticks)) begin
                        if (bit_idx != 3'd7) begin
                            advance_bit();
                        end else if (seq_step == ST_R_LO) begin
                            low_byte = shift_reg;
                            enter_step(ST_R_HI);
                        end else begin
                            reading = {shift_reg[3:0], low_byte[7:4]};
                            enter_step(ST_IDLE);
                            res.busy_res = 1'b0;
                            res.done_res = 1'b1;
                        end
                    end
                end
            end
            default: enter_step(ST_IDLE);
        endcase
        res.temperature = reading;
        return res;
    endfunction

    function automatic void log_mismatch(string what, t_out_item want, t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch (%s): expected drive %0b busy %0b done %0b temp %02h",
                     $time, what, want.drive_low, want.busy_res, want.done_res,
                     want.temperature);
            $display("    got drive %0b busy %0b done %0b temp %02h",
                     got.drive_low, got.busy_res, got.done_res, got.temperature);
        end
    endfunction

    // tick sender
    int send_gap = 0;
    always @(negedge i_clk) begin
        logic     nv;
        t_in_item ni;
        nv = in_valid;
        ni = in_item;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!in_valid || in_taken) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 13);
            end else if (ticks_to_send.size() != 0) begin
                ni = ticks_to_send.pop_front();
                nv = 1'b1;
            end
        end
        in_valid <= nv;
        in_item <= ni;
    end

    // result receiver stalls
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_started = 1'b0;
    always @(negedge i_clk) begin
        logic st;
        st = 1'b0;
        if (i_rst_n) begin
            if (hold_out_req && !hold_started) begin
                hold_started = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                st = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                st = 1'b1;
            end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
                recv_gap = $urandom_range(0, 13);
                st = 1'b1;
            end
        end
        out_stall <= st;
    end

    // monitor: predict on every tick transfer, check every result transfer
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (in_valid && o_in_stall)
                input_stall_cycles++;
            if (in_valid && !o_in_stall) begin
                bus_results_due.push_back(predict_bus_tick(in_item));
                in_taken = 1'b1;
                ticks_taken++;
            end
            if (o_out_valid && !out_stall) begin
                if (bus_results_due.size() == 0) begin
                    log_mismatch("unexpected result", '0, o_out_item);
                end else begin
                    want = bus_results_due.pop_front();
                    if (want.drive_low !== o_out_item.drive_low
                        || want.busy_res !== o_out_item.busy_res
                        || want.done_res !== o_out_item.done_res
                        || want.temperature !== o_out_item.temperature)
                        log_mismatch("field", want, o_out_item);
                end
                if (o_out_item.done_res === 1'b1)
                    reads_completed++;
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, int unsigned value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RESET_LOW:  timing.reset_low_ticks = value[OWTR_CFG_W-1:0];
            REG_PRES_TMO:   timing.presence_timeout_ticks = value[OWTR_CFG_W-1:0];
            REG_RECOVERY:   timing.reset_recovery_ticks = value[OWTR_CFG_W-1:0];
            REG_SLOT_START: timing.slot_start_ticks = value[OWTR_CFG_W-1:0];
            REG_SLOT_HOLD:  timing.slot_hold_ticks = value[OWTR_CFG_W-1:0];
            default:        ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_timing(int unsigned rst_low, int unsigned pres, int unsigned recov,
                               int unsigned slot_start, int unsigned slot_hold);
        apb_write(REG_RESET_LOW, rst_low);
        apb_write(REG_PRES_TMO, pres);
        apb_write(REG_RECOVERY, recov);
        apb_write(REG_SLOT_START, slot_start);
        apb_write(REG_SLOT_HOLD, slot_hold);
        settings_used++;
    endtask

    task automatic push_tick(logic req, logic line);
        t_in_item it;
        it.req_type = req;
        it.line_level = line;
        ticks_to_send.push_back(it);
    endtask

    task automatic push_ticks(int count, int start_pct, int low_pct);
        for (int n = 0; n < count; n++)
            push_tick($urandom_range(0, 99) < start_pct, !($urandom_range(0, 99) < low_pct));
    endtask

    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || in_valid || bus_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // feed plain ticks until the running read sequence is over
    task automatic settle_sequencer(int low_pct);
        wait_drained();
        while (seq_step != ST_IDLE) begin
            push_ticks(32, 0, low_pct);
            wait_drained();
        end
    endtask

    function automatic int unsigned pick_ticks();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(3, 8);
        return $urandom_range(0, 2);
    endfunction

    initial begin
        timing = '{RST_RESET_LOW, RST_PRES_TMO, RST_RECOVERY, RST_SLOT_START, RST_SLOT_HOLD};
        seq_step = ST_IDLE;
        bit_idx = '0;
        tick_count = '0;
        shift_reg = '0;
        low_byte = '0;
        reading = '0;
        slot_body = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // writes outside the register map change nothing
        apb_write(REG_BEYOND_LO, 32'h0000_0001);
        apb_write(REG_BEYOND_HI, 32'hFFFF_FFFF);

        // reset timing: idle ticks, a start, starts while busy, part of the reset pulse
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_ticks(40, 0, 50);
        wait_drained();

        // zero registers cut the running pulse short: every phase one tick,
        // line high then line low throughout
        load_timing(0, 0, 0, 0, 0);
        settle_sequencer(0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        settle_sequencer(100);

        for (int ph = 0; ph < 3; ph++) begin
            int low_pct;
            low_pct = $urandom_range(10, 90);
            load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
            push_ticks(20, 8, low_pct);
            // sender pause in the middle of a sequence
            wait_drained();
            push_ticks(20, 8, low_pct);
            if (ph == 1)
                hold_out_req = 1'b1;
            settle_sequencer(low_pct);
        end

        // largest timings, then shortened while the reset pulse is under way
        load_timing(1023, 1023, 1023, 1023, 1023);
        push_tick(1'b1, 1'b1);
        push_ticks(60, 0, 0);
        wait_drained();
        load_timing(1, 3, 1, 1, 2);
        settle_sequencer(0);

        calm_tail = 1'b1;
        load_timing(pick_ticks(), pick_ticks(), pick_ticks(), 1, 2);
        push_ticks(60, 8, 50);
        settle_sequencer(50);

        repeat (4) @(posedge i_clk);
        $display("covered %0d ticks over %0d timing settings, %0d completed temperature reads",
                 ticks_taken, settings_used, reads_completed);
        $display("tick input was held off for %0d cycles, %0d mismatches",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0 && bus_results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout with %0d results outstanding", bus_results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
